// File: design/mta_pkg.sv
// Shared types and constants of the mosaic tile averager.
`default_nettype none
package mta_pkg;

  localparam int PIX_W = 8;
  localparam int SUM_W = 28;
  localparam int CFG_W = 11;
  localparam int COL_W = 10;
  localparam int SIZE_W = 11;

  typedef enum logic [1:0] {
    REG_FRAME_W = 2'd0,
    REG_FRAME_H = 2'd1,
    REG_BLOCK_W = 2'd2,
    REG_BLOCK_H = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] frame_width;
    logic [CFG_W-1:0] frame_height;
    logic [CFG_W-1:0] block_width;
    logic [CFG_W-1:0] block_height;
  } cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0] blue;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] red;
  } sums_t;

  typedef struct packed {
    logic [COL_W-1:0]  tile_col;
    logic [COL_W-1:0]  tile_row;
    logic [SIZE_W-1:0] tile_w;
    logic [SIZE_W-1:0] tile_h;
    logic              frame_done;
  } meta_t;

endpackage
`default_nettype wire

// File: design/mta_front.sv
// Front end: frame position tracking and per tile column sum accumulation.
`default_nettype none
module mta_front import mta_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024,
  localparam int AW = $clog2(MAX_WIDTH),
  localparam int HW = $clog2(MAX_HEIGHT),
  localparam int CNTW = AW + HW + 2,
  localparam int QW = CNTW + $bits(sums_t) + $bits(meta_t)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cfg_t             cfg,
  input  wire logic             in_push,
  output logic                  in_full,
  input  wire logic [PIX_W-1:0] in_pix_blue,
  input  wire logic [PIX_W-1:0] in_pix_green,
  input  wire logic [PIX_W-1:0] in_pix_red,
  output logic                  q_push,
  output logic [QW-1:0]         q_data,
  input  wire logic             q_full
);

  localparam int XW = ((AW + 1 > CFG_W) ? AW + 1 : CFG_W) + 1;
  localparam int YW = ((HW + 1 > CFG_W) ? HW + 1 : CFG_W) + 1;
  localparam int TWW = AW + 1;
  localparam int THW = HW + 1;

  logic [AW-1:0] col_pos_r, col_pos_nxt, tile_start_r, tile_start_nxt;
  logic [AW-1:0] tile_idx_r, tile_idx_nxt;
  logic [HW-1:0] row_pos_r, row_pos_nxt, band_start_r, band_start_nxt;
  logic [HW-1:0] band_idx_r, band_idx_nxt;

  logic          busy_r, emit_r, load_r;
  logic [AW-1:0] idx_r;
  logic [PIX_W-1:0] pb_r, pg_r, pr_r;
  logic [TWW-1:0] tw_r;
  logic [THW-1:0] th_r;
  meta_t         meta_r;
  logic [3*SUM_W-1:0] rd_r;
  logic [3*SUM_W-1:0] mem [MAX_WIDTH];

  logic [XW-1:0] fw_raw, fw, bw, te_sum, tile_end, c1, tw;
  logic [YW-1:0] fh_raw, fh, bh, be_sum, band_end, r1, th;
  logic          accept, restart, col_last, row_last, line_end;
  logic [AW-1:0] c, ts, ti;
  logic [HW-1:0] rp, bs, bi;
  meta_t         meta;
  sums_t         sums_new, sums_old;

  assign accept  = in_push && !in_full;
  assign in_full = busy_r || q_full;

  always_comb begin
    fw_raw = XW'(cfg.frame_width);
    fh_raw = YW'(cfg.frame_height);
    fw = (fw_raw == '0) ? XW'(1) : ((fw_raw > XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : fw_raw);
    fh = (fh_raw == '0) ? YW'(1) : ((fh_raw > YW'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT) : fh_raw);
    bw = (cfg.block_width == '0) ? XW'(1) : XW'(cfg.block_width);
    bh = (cfg.block_height == '0) ? YW'(1) : YW'(cfg.block_height);

    // out-of-frame position after a size change starts a new frame
    restart = (XW'(col_pos_r) >= fw) || (YW'(row_pos_r) >= fh);
    c  = restart ? '0 : col_pos_r;
    ts = restart ? '0 : tile_start_r;
    ti = restart ? '0 : tile_idx_r;
    rp = restart ? '0 : row_pos_r;
    bs = restart ? '0 : band_start_r;
    bi = restart ? '0 : band_idx_r;

    te_sum   = XW'(ts) + bw;
    tile_end = (te_sum > fw) ? fw : te_sum;
    be_sum   = YW'(bs) + bh;
    band_end = (be_sum > fh) ? fh : be_sum;
    c1 = XW'(c) + XW'(1);
    r1 = YW'(rp) + YW'(1);
    col_last = c1 >= tile_end;
    row_last = r1 >= band_end;
    line_end = c1 >= fw;
    tw = tile_end - XW'(ts);
    th = band_end - YW'(bs);

    meta.tile_col   = COL_W'(ti);
    meta.tile_row   = COL_W'(bi);
    meta.tile_w     = SIZE_W'(tw);
    meta.tile_h     = SIZE_W'(th);
    meta.frame_done = line_end && (r1 >= fh);

    col_pos_nxt    = AW'(c1);
    tile_start_nxt = col_last ? AW'(c1) : ts;
    tile_idx_nxt   = col_last ? ti + AW'(1) : ti;
    row_pos_nxt    = rp;
    band_start_nxt = bs;
    band_idx_nxt   = bi;
    if (line_end) begin
      col_pos_nxt    = '0;
      tile_start_nxt = '0;
      tile_idx_nxt   = '0;
      row_pos_nxt    = HW'(r1);
      if (r1 >= fh) begin
        row_pos_nxt    = '0;
        band_start_nxt = '0;
        band_idx_nxt   = '0;
      end else if (r1 >= band_end) begin
        band_start_nxt = HW'(r1);
        band_idx_nxt   = bi + HW'(1);
      end
    end
  end

  always_comb begin
    sums_old = sums_t'(rd_r);
    if (load_r) begin
      sums_new.blue  = SUM_W'(pb_r);
      sums_new.green = SUM_W'(pg_r);
      sums_new.red   = SUM_W'(pr_r);
    end else begin
      sums_new.blue  = sums_old.blue + SUM_W'(pb_r);
      sums_new.green = sums_old.green + SUM_W'(pg_r);
      sums_new.red   = sums_old.red + SUM_W'(pr_r);
    end
  end

  assign q_push = busy_r && emit_r;
  assign q_data = {CNTW'(tw_r) * CNTW'(th_r), sums_new, meta_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      col_pos_r    <= '0;
      tile_start_r <= '0;
      tile_idx_r   <= '0;
      row_pos_r    <= '0;
      band_start_r <= '0;
      band_idx_r   <= '0;
    end else begin
      busy_r <= accept;
      if (accept) begin
        col_pos_r    <= col_pos_nxt;
        tile_start_r <= tile_start_nxt;
        tile_idx_r   <= tile_idx_nxt;
        row_pos_r    <= row_pos_nxt;
        band_start_r <= band_start_nxt;
        band_idx_r   <= band_idx_nxt;
      end
    end
  end

  // payload and sum memory: read on accept, write back in the next cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r   <= mem[ti];
      idx_r  <= ti;
      load_r <= (rp == bs);
      emit_r <= col_last && row_last;
      pb_r   <= in_pix_blue;
      pg_r   <= in_pix_green;
      pr_r   <= in_pix_red;
      tw_r   <= TWW'(tw);
      th_r   <= THW'(th);
      meta_r <= meta;
    end
    if (busy_r) begin
      mem[idx_r] <= sums_new;
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy_r) else $error("accepted pixel not processed");
  a_busy_one: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |=> !busy_r) else $error("write-back stage held more than one cycle");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> $past(!q_full)) else $error("tile job pushed into full queue");

endmodule
`default_nettype wire

// File: design/mta_fifo.sv
// Two-entry queue carrying completed tile jobs from front to back.
`default_nettype none
module mta_fifo #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      rdata,
  output logic              empty
);

  logic [W-1:0] slot_r [2];
  logic         wr_ptr_r, rd_ptr_r;
  logic [1:0]   count_r;

  assign full  = count_r == 2'd2;
  assign empty = count_r == 2'd0;
  assign rdata = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push && !full) wr_ptr_r <= !wr_ptr_r;
      if (pop && !empty) rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + 2'(push && !full) - 2'(pop && !empty);
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) slot_r[wr_ptr_r] <= wdata;
  end

endmodule
`default_nettype wire

// File: design/mta_back.sv
// Back end: restoring divider turning tile sums into saturated 8-bit means.
`default_nettype none
module mta_back import mta_pkg::*; #(
  parameter int CNTW = 22,
  localparam int QW = CNTW + $bits(sums_t) + $bits(meta_t)
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         q_empty,
  input  wire logic [QW-1:0] q_data,
  output logic              q_pop,
  output logic              out_empty,
  input  wire logic         out_pop,
  output logic [PIX_W-1:0]  out_avg_blue,
  output logic [PIX_W-1:0]  out_avg_green,
  output logic [PIX_W-1:0]  out_avg_red,
  output meta_t             out_meta
);

  localparam int DW = SUM_W + CNTW + 9;

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_DONE} state_t;

  state_t           state_r;
  logic [3:0]       step_r;
  logic [CNTW-1:0]  cnt_r;
  logic [SUM_W-1:0] rem_r [3];
  logic [PIX_W-1:0] quo_r [3];
  logic [2:0]       sat_r;
  meta_t            meta_r;

  logic [CNTW-1:0]  q_cnt;
  sums_t            q_sums;
  meta_t            q_meta;
  logic [DW-1:0]    divisor;

  assign {q_cnt, q_sums, q_meta} = q_data;
  assign divisor = DW'(cnt_r) << step_r;
  assign q_pop   = (state_r == ST_IDLE) && !q_empty;
  assign out_empty = state_r != ST_DONE;
  assign out_avg_blue  = sat_r[0] ? '1 : quo_r[0];
  assign out_avg_green = sat_r[1] ? '1 : quo_r[1];
  assign out_avg_red   = sat_r[2] ? '1 : quo_r[2];
  assign out_meta = meta_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= 4'd0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            state_r  <= ST_DIV;
            step_r   <= 4'd8;
            cnt_r    <= q_cnt;
            meta_r   <= q_meta;
            rem_r[0] <= q_sums.blue;
            rem_r[1] <= q_sums.green;
            rem_r[2] <= q_sums.red;
            sat_r    <= 3'b000;
            for (int k = 0; k < 3; k++) quo_r[k] <= '0;
          end
        end
        ST_DIV: begin
          // top step only detects a quotient above 255
          for (int k = 0; k < 3; k++) begin
            if (DW'(rem_r[k]) >= divisor) begin
              if (step_r == 4'd8) begin
                sat_r[k] <= 1'b1;
              end else begin
                rem_r[k] <= SUM_W'(DW'(rem_r[k]) - divisor);
                quo_r[k][step_r[2:0]] <= 1'b1;
              end
            end
          end
          if (step_r == 4'd0) state_r <= ST_DONE;
          else step_r <= step_r - 4'd1;
        end
        ST_DONE: begin
          if (out_pop) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: design/mosaic_tile_averager_top.sv
// Top level of the mosaic tile averager: config registers, front, job queue, back.
//
//  channel  direction  handshake             payload
//  in_      input      in_push / in_full     in_pix_blue, in_pix_green, in_pix_red
//  out_     output     out_empty / out_pop   averages, tile position, size, frame_done
//  cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// In the front a pixel's sum memory is read on transfer and written back next,
// so in_full is high during each write-back and while the job queue is full.
// A tile job is queued at the write-back of its last pixel; the back loads it and runs
// 9 shared divider steps (overflow check plus 8 quotient bits), and after the
// pop it returns to idle and loads the next job from there.
// Reset clears position state and sets config to 640x480 with 1x1 blocks; sum memory
// is not cleared (first row of each band loads rather than adds). cfg_ready is always high.
`default_nettype none
module mosaic_tile_averager_top import mta_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire logic [PIX_W-1:0]  in_pix_blue,
  input  wire logic [PIX_W-1:0]  in_pix_green,
  input  wire logic [PIX_W-1:0]  in_pix_red,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output logic [PIX_W-1:0]       out_avg_blue,
  output logic [PIX_W-1:0]       out_avg_green,
  output logic [PIX_W-1:0]       out_avg_red,
  output logic [COL_W-1:0]       out_tile_col,
  output logic [COL_W-1:0]       out_tile_row,
  output logic [SIZE_W-1:0]      out_tile_w,
  output logic [SIZE_W-1:0]      out_tile_h,
  output logic                   out_frame_done,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int HW = $clog2(MAX_HEIGHT);
  localparam int CNTW = AW + HW + 2;
  localparam int QW = CNTW + $bits(sums_t) + $bits(meta_t);

  cfg_t          cfg_r;
  logic          q_push, q_full, q_pop, q_empty;
  logic [QW-1:0] q_wdata, q_rdata;
  meta_t         meta;

  assign cfg_ready = 1'b1;

  // config transfer: new values apply from the next pixel on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width  <= CFG_W'(640);
      cfg_r.frame_height <= CFG_W'(480);
      cfg_r.block_width  <= CFG_W'(1);
      cfg_r.block_height <= CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_FRAME_W: cfg_r.frame_width  <= cfg_data;
        REG_FRAME_H: cfg_r.frame_height <= cfg_data;
        REG_BLOCK_W: cfg_r.block_width  <= cfg_data;
        REG_BLOCK_H: cfg_r.block_height <= cfg_data;
        default: ;
      endcase
    end
  end

  mta_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk, .rst_n, .cfg(cfg_r),
    .in_push, .in_full, .in_pix_blue, .in_pix_green, .in_pix_red,
    .q_push, .q_data(q_wdata), .q_full
  );

  mta_fifo #(.W(QW)) u_queue (
    .clk, .rst_n, .push(q_push), .wdata(q_wdata), .full(q_full),
    .pop(q_pop), .rdata(q_rdata), .empty(q_empty)
  );

  mta_back #(.CNTW(CNTW)) u_back (
    .clk, .rst_n, .q_empty, .q_data(q_rdata), .q_pop,
    .out_empty, .out_pop, .out_avg_blue, .out_avg_green, .out_avg_red,
    .out_meta(meta)
  );

  assign out_tile_col   = meta.tile_col;
  assign out_tile_row   = meta.tile_row;
  assign out_tile_w     = meta.tile_w;
  assign out_tile_h     = meta.tile_h;
  assign out_frame_done = meta.frame_done;

endmodule
`default_nettype wire

// File: tb/tb_mosaic_tile_averager_top.sv
// Testbench for the mosaic tile averager: directed and random frames against a tile-mean predictor.
`default_nettype none
module tb_mosaic_tile_averager_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mta_pkg::*;

  // one expected or observed tile mean
  typedef struct {
    logic [PIX_W-1:0]  blue;
    logic [PIX_W-1:0]  green;
    logic [PIX_W-1:0]  red;
    logic [COL_W-1:0]  col;
    logic [COL_W-1:0]  row;
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
    logic              done;
  } tile_mean_t;

  localparam int MAX_W = 1024;
  localparam int MAX_H = 1024;
  localparam int DRAIN_CYCLES = 32;  // covers front and back processing, with margin

  logic              clk;
  logic              rst_n;
  logic              in_push;
  logic              in_full;
  logic [PIX_W-1:0]  in_pix_blue;
  logic [PIX_W-1:0]  in_pix_green;
  logic [PIX_W-1:0]  in_pix_red;
  logic              out_empty;
  logic              out_pop;
  logic [PIX_W-1:0]  out_avg_blue;
  logic [PIX_W-1:0]  out_avg_green;
  logic [PIX_W-1:0]  out_avg_red;
  logic [COL_W-1:0]  out_tile_col;
  logic [COL_W-1:0]  out_tile_row;
  logic [SIZE_W-1:0] out_tile_w;
  logic [SIZE_W-1:0] out_tile_h;
  logic              out_frame_done;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [1:0]        cfg_index;
  logic [CFG_W-1:0]  cfg_data;

  mosaic_tile_averager_top i_dut (.*);

  // predictor state: registers as written, per-column sums, frame position
  logic [CFG_W-1:0] reg_fw, reg_fh, reg_bw, reg_bh;
  logic [SUM_W-1:0] acc_blue [MAX_W];
  logic [SUM_W-1:0] acc_green[MAX_W];
  logic [SUM_W-1:0] acc_red  [MAX_W];
  int unsigned      pos_col, pos_row, band_row0, tile_col0, tile_num, band_num;

  tile_mean_t pending_means[$];
  int         err_count;
  int         pix_count;
  int         tile_count;
  int         phase_count;
  bit         steady;       // both sides run without gaps
  int         hold_cycles;  // receiver holds off this long once, then clears

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

  function automatic int unsigned eff_size(logic [CFG_W-1:0] v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [PIX_W-1:0] mean_of(logic [SUM_W-1:0] s, int unsigned n);
    int unsigned q;
    q = s / n;
    return (q > 255) ? 8'hFF : q[PIX_W-1:0];
  endfunction

  task automatic restart_position();
    pos_col = 0; pos_row = 0; band_row0 = 0; tile_col0 = 0; tile_num = 0; band_num = 0;
  endtask

  // advance the frame position by one pixel and queue the tile mean it completes
  task automatic predict_pixel(logic [PIX_W-1:0] b, logic [PIX_W-1:0] g, logic [PIX_W-1:0] r);
    int unsigned fw, fh, bw, bh, tend, bend, idx, tw, th;
    bit         col_last, row_last, line_end;
    tile_mean_t m;
    fw = eff_size(reg_fw, MAX_W);
    fh = eff_size(reg_fh, MAX_H);
    bw = (reg_bw == 0) ? 1 : reg_bw;
    bh = (reg_bh == 0) ? 1 : reg_bh;
    if (pos_col >= fw || pos_row >= fh) restart_position();
    tend = (tile_col0 + bw > fw) ? fw : tile_col0 + bw;
    bend = (band_row0 + bh > fh) ? fh : band_row0 + bh;
    idx = tile_num % MAX_W;
    if (pos_row == band_row0) begin
      acc_blue[idx] = b; acc_green[idx] = g; acc_red[idx] = r;
    end else begin
      acc_blue[idx]  = acc_blue[idx] + b;
      acc_green[idx] = acc_green[idx] + g;
      acc_red[idx]   = acc_red[idx] + r;
    end
    col_last = (pos_col + 1) >= tend;
    row_last = (pos_row + 1) >= bend;
    line_end = (pos_col + 1) >= fw;
    if (col_last && row_last) begin
      tw = tend - tile_col0;
      th = bend - band_row0;
      m.blue  = mean_of(acc_blue[idx], tw * th);
      m.green = mean_of(acc_green[idx], tw * th);
      m.red   = mean_of(acc_red[idx], tw * th);
      m.col   = tile_num[COL_W-1:0];
      m.row   = band_num[COL_W-1:0];
      m.w     = tw[SIZE_W-1:0];
      m.h     = th[SIZE_W-1:0];
      m.done  = line_end && (pos_row + 1) >= fh;
      pending_means.push_back(m);
    end
    if (col_last) begin
      tile_col0 = pos_col + 1;
      tile_num++;
    end
    pos_col++;
    if (line_end) begin
      pos_col = 0; tile_col0 = 0; tile_num = 0;
      pos_row++;
      if (pos_row >= fh) restart_position();
      else if (pos_row >= bend) begin
        band_row0 = pos_row;
        band_num++;
      end
    end
  endtask

  function automatic int draw_gap();
    return steady ? 0 : $urandom_range(0, 8);
  endfunction

  // one pixel transfer; push stays high afterwards so back-to-back pixels need no drop
  task automatic send_pixel(logic [PIX_W-1:0] b, logic [PIX_W-1:0] g, logic [PIX_W-1:0] r);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push      <= 1'b1;
    in_pix_blue  <= b;
    in_pix_green <= g;
    in_pix_red   <= r;
    do @(posedge clk); while (in_full);
    predict_pixel(b, g, r);
    pix_count++;
  endtask

  // valid stays high between writes; the caller drops it after the last one
  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
    in_push   <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FRAME_W: reg_fw = val;
      REG_FRAME_H: reg_fh = val;
      REG_BLOCK_W: reg_bw = val;
      REG_BLOCK_H: reg_bh = val;
      default: ;
    endcase
  endtask

  // wait until every queued mean is out, then let trailing pixels settle
  task automatic drain();
    @(posedge clk);
    in_push <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_geometry(logic [CFG_W-1:0] fw, logic [CFG_W-1:0] fh,
                              logic [CFG_W-1:0] bw, logic [CFG_W-1:0] bh);
    drain();
    write_reg(REG_FRAME_W, fw);
    write_reg(REG_FRAME_H, fh);
    write_reg(REG_BLOCK_W, bw);
    write_reg(REG_BLOCK_H, bh);
    cfg_valid <= 1'b0;
    phase_count++;
  endtask

  // a whole frame, so the position is back at the origin when it ends
  task automatic send_frame(bit fixed, logic [PIX_W-1:0] val);
    int n;
    n = eff_size(reg_fw, MAX_W) * eff_size(reg_fh, MAX_H);
    repeat (n) begin
      if (fixed) send_pixel(val, val, val);
      else send_pixel(PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)),
                      PIX_W'($urandom_range(0, 255)));
    end
  endtask

  // 1x1 tiles: every pixel comes back unchanged; walk each bit high and low in green, in blue and red bits 0 to 5
  task automatic test_passthrough();
    set_geometry(11'd4, 11'd4, 11'd1, 11'd1);
    send_pixel(8'h00, 8'hFF, 8'h00);
    send_pixel(8'hFF, 8'h00, 8'hFF);
    for (int k = 0; k < PIX_W; k++) send_pixel(8'd1 << k, ~(8'd1 << k), 8'd1 << k);
    for (int k = 0; k < 6; k++) send_pixel(~(8'd1 << k), 8'd1 << k, ~(8'd1 << k));
  endtask

  // clipped edge tiles at full scale, zero sizes read as one
  task automatic test_clipping();
    set_geometry(11'd5, 11'd3, 11'd2, 11'd2);
    send_frame(1'b1, 8'hFF);
    set_geometry(11'd0, 11'd0, 11'd0, 11'd0);
    send_frame(1'b1, 8'h00);
    send_frame(1'b1, 8'hFF);
  endtask

  // oversized registers: frame clamps to the maximum width, blocks span the frame but for a 1000-wide block
  task automatic test_extremes();
    set_geometry(11'd2047, 11'd0, 11'd1000, 11'd2047);
    send_frame(1'b0, 8'h00);
    set_geometry(11'd16, 11'd1, 11'd2047, 11'd1024);
    send_frame(1'b0, 8'h00);
  endtask

  // receiver stalls a long time while pixels keep coming: input must back up
  task automatic test_backpressure();
    set_geometry(11'd8, 11'd8, 11'd1, 11'd1);
    steady = 1'b1;
    hold_cycles = 300;
    send_frame(1'b0, 8'h00);
    steady = 1'b0;
  endtask

  task automatic test_random_frames();
    int fw, fh;
    while (pix_count < 1200) begin
      fw = $urandom_range(1, 16);
      fh = $urandom_range(1, 8);
      set_geometry(CFG_W'(fw), CFG_W'(fh), CFG_W'($urandom_range(0, fw + 3)),
                   CFG_W'($urandom_range(0, fh + 3)));
      steady = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 2)) send_frame(1'b0, 8'h00);
      steady = 1'b0;
    end
  endtask

  // result side: pop with random holds, compare each transfer to the oldest mean
  initial begin
    int         gap;
    tile_mean_t exp_m;
    out_pop = 1'b0;
    @(posedge rst_n);
    forever begin
      gap = (hold_cycles > 0) ? hold_cycles : draw_gap();
      hold_cycles = 0;
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      tile_count++;
      if (pending_means.size() == 0) begin
        $error("tile mean with no pixel to account for it");
        err_count++;
      end else begin
        exp_m = pending_means.pop_front();
        if (out_avg_blue !== exp_m.blue) begin
          $error("avg_blue exp %0d got %0d", exp_m.blue, out_avg_blue); err_count++;
        end
        if (out_avg_green !== exp_m.green) begin
          $error("avg_green exp %0d got %0d", exp_m.green, out_avg_green); err_count++;
        end
        if (out_avg_red !== exp_m.red) begin
          $error("avg_red exp %0d got %0d", exp_m.red, out_avg_red); err_count++;
        end
        if (out_tile_col !== exp_m.col) begin
          $error("tile_col exp %0d got %0d", exp_m.col, out_tile_col); err_count++;
        end
        if (out_tile_row !== exp_m.row) begin
          $error("tile_row exp %0d got %0d", exp_m.row, out_tile_row); err_count++;
        end
        if (out_tile_w !== exp_m.w) begin
          $error("tile_w exp %0d got %0d", exp_m.w, out_tile_w); err_count++;
        end
        if (out_tile_h !== exp_m.h) begin
          $error("tile_h exp %0d got %0d", exp_m.h, out_tile_h); err_count++;
        end
        if (out_frame_done !== exp_m.done) begin
          $error("frame_done exp %0d got %0d", exp_m.done, out_frame_done); err_count++;
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_pix_blue = '0;
    in_pix_green = '0;
    in_pix_red = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_FRAME_W;
    cfg_data = '0;
    err_count = 0; pix_count = 0; tile_count = 0; phase_count = 0;
    steady = 1'b0;
    hold_cycles = 0;
    reg_fw = 11'd640; reg_fh = 11'd480; reg_bw = 11'd1; reg_bh = 11'd1;
    restart_position();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_passthrough();
    test_clipping();
    test_backpressure();
    test_extremes();
    test_random_frames();
    drain();
    $display("covered %0d pixels and %0d tile means over %0d geometries",
             pix_count, tile_count, phase_count);
    $display("incl. 1x1 passthrough, clipped edges, clamped sizes, long output stall");
    if (err_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire

// File: sim.f
design/mta_pkg.sv
design/mta_front.sv
design/mta_fifo.sv
design/mta_back.sv
design/mosaic_tile_averager_top.sv
tb/tb_mosaic_tile_averager_top.sv
